/* design/four_level_page_table_walker_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the four level page table walker
// Both macros sample on the rising edge of clk and are disabled while arst_n
// is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Property that holds in the same cycle as its antecedent
`define PTW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that holds in the cycle after its antecedent
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the four level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	// Fixed field widths
	localparam int PA_W = 52;
	localparam int VA_W = 48;
	localparam int ENTRY_W = 64;

	// Default physical address width handed to the top level
	localparam int PHYS_ADDR_BITS_DEF = 52;

	// Request types
	localparam logic REQ_TRANSLATE = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	// Result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
	localparam logic [1:0] ST_BAD_ROOT = 2'd2;
	localparam logic [1:0] ST_IDLE_ENTRY = 2'd3;

	// Page sizes
	localparam logic [1:0] PS_4K = 2'd0;
	localparam logic [1:0] PS_2M = 2'd1;
	localparam logic [1:0] PS_1G = 2'd2;

	// Walk levels
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD = 2'd2;
	localparam logic [1:0] LVL_PT = 2'd3;

	// Entry flag bit positions
	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE = 7;

	typedef struct packed {
		logic req_type;
		logic [VA_W-1:0] virtual_address;
		logic [ENTRY_W-1:0] entry_data;
	} ptw_req_t;

	typedef struct packed {
		logic result_kind;
		logic [PA_W-1:0] entry_address;
		logic [PA_W-1:0] phys_addr;
		logic [1:0] status;
		logic [1:0] page_size;
	} ptw_rsp_t;

endpackage

/* design/four_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four level table walk with 4 KiB, 2 MiB and 1 GiB pages, one result per
// request.
// ----------------------------------------------------------------------------
// The walker takes one request transfer per cycle while in_ready is high and
// returns exactly one response for each, in order. A request lands in an
// input register; the walk step (present and page size checks, index select,
// frame mask and add) runs from there into the response register while the
// walk state updates. Table entry reads are not issued by the block: the
// response carries the entry address and the caller returns the entry as a
// request. The user must write root_table_base through cfg_we/cfg_data only
// while idle; the block itself does not enforce this.
`include "four_level_page_table_walker_defines.svh"

module four_level_page_table_walker
	import ptw_pkg::*;
#(
	parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [PA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  ptw_req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ptw_rsp_t out_data
);

	localparam logic [PA_W-1:0] PHYS_MASK = {PA_W{1'b1}} >> (PA_W - PHYS_ADDR_BITS);
	localparam logic [PA_W-1:0] FRAME_MASK = PHYS_MASK & ~(PA_W'(12'hFFF));
	localparam logic [PA_W-1:0] MASK_1G = ~(PA_W'(30'h3FFF_FFFF));
	localparam logic [PA_W-1:0] MASK_2M = ~(PA_W'(21'h1F_FFFF));

	logic [PA_W-1:0] root_q;
	logic walk_busy_q;
	logic [1:0] walk_level_q;
	logic [VA_W-1:0] held_va_q;

	logic valid_s1;
	ptw_req_t req_s1;
	logic out_valid_q;
	ptw_rsp_t out_data_q;

	logic advance;
	logic in_xfer;

	ptw_rsp_t rsp;
	logic nxt_busy;
	logic [1:0] nxt_level;
	logic [VA_W-1:0] nxt_va;

	logic root_ok;
	logic [PA_W-1:0] frame;
	logic [8:0] idx;
	logic [VA_W-1:0] va;

	// Handshake: stage 1 moves on when the response register is free or drains
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_we) begin
			root_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1 <= in_data;
		end
	end

	// Index of the held address into the table one level below the current one
	always_comb begin
		va = held_va_q;
		case (walk_level_q)
			LVL_PML4: idx = va[38:30];
			LVL_PDPT: idx = va[29:21];
			default:  idx = va[20:12];
		endcase
	end

	assign root_ok = (root_q[11:0] == 12'h000) && ((root_q & ~PHYS_MASK) == '0);
	assign frame = req_s1.entry_data[PA_W-1:0] & FRAME_MASK;

	// Walk step
	always_comb begin
		rsp = '0;
		nxt_busy = walk_busy_q;
		nxt_level = walk_level_q;
		nxt_va = held_va_q;
		if (req_s1.req_type == REQ_TRANSLATE) begin
			nxt_level = LVL_PML4;
			if (!root_ok) begin
				nxt_busy = 1'b0;
				rsp.result_kind = KIND_DONE;
				rsp.status = ST_BAD_ROOT;
			end else begin
				nxt_busy = 1'b1;
				nxt_va = req_s1.virtual_address;
				rsp.result_kind = KIND_READ;
				rsp.entry_address = root_q + PA_W'({req_s1.virtual_address[47:39], 3'b000});
			end
		end else if (!walk_busy_q) begin
			rsp.result_kind = KIND_DONE;
			rsp.status = ST_IDLE_ENTRY;
		end else if (!req_s1.entry_data[BIT_PRESENT]) begin
			nxt_busy = 1'b0;
			nxt_level = LVL_PML4;
			rsp.result_kind = KIND_DONE;
			rsp.status = ST_NOT_MAPPED;
		end else begin
			// Next level pointer unless a leaf ends the walk here
			rsp.result_kind = KIND_READ;
			rsp.entry_address = frame + PA_W'({idx, 3'b000});
			nxt_level = walk_level_q + 2'd1;
			case (walk_level_q)
				LVL_PDPT: begin
					if (req_s1.entry_data[BIT_LARGE]) begin
						nxt_busy = 1'b0;
						nxt_level = LVL_PML4;
						rsp.result_kind = KIND_DONE;
						rsp.entry_address = '0;
						rsp.phys_addr = (frame & MASK_1G) | PA_W'(va[29:0]);
						rsp.page_size = PS_1G;
					end
				end
				LVL_PD: begin
					if (req_s1.entry_data[BIT_LARGE]) begin
						nxt_busy = 1'b0;
						nxt_level = LVL_PML4;
						rsp.result_kind = KIND_DONE;
						rsp.entry_address = '0;
						rsp.phys_addr = (frame & MASK_2M) | PA_W'(va[20:0]);
						rsp.page_size = PS_2M;
					end
				end
				LVL_PT: begin
					nxt_busy = 1'b0;
					nxt_level = LVL_PML4;
					rsp.result_kind = KIND_DONE;
					rsp.entry_address = '0;
					rsp.phys_addr = frame | PA_W'(va[11:0]);
					rsp.page_size = PS_4K;
				end
				default: begin
				end
			endcase
		end
	end

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_busy_q <= 1'b0;
			walk_level_q <= LVL_PML4;
			held_va_q <= '0;
		end else if (advance) begin
			walk_busy_q <= nxt_busy;
			walk_level_q <= nxt_level;
			held_va_q <= nxt_va;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= rsp;
		end
	end

	// Checks
	`PTW_ASSERT_SAME(a_idle_top, !walk_busy_q, walk_level_q == LVL_PML4, "idle walker not at top level")
	`PTW_ASSERT_NEXT(a_adv_loads, advance, out_valid_q, "step did not load a response")
	`PTW_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(req_s1), "stalled request lost")
	`PTW_ASSERT_NEXT(a_done_idle, advance && rsp.result_kind == KIND_DONE && rsp.status != ST_IDLE_ENTRY, !walk_busy_q, "walk still busy after finish")

endmodule
